>>> rtl/core/smm_pkg.sv
package smm_pkg;

  localparam int LANES     = 4;
  localparam int SAMPLE_W  = 32;
  localparam int ACC_W     = 53;
  localparam int MODE_W    = 2;
  localparam int GE_CFG_W  = 21;
  localparam int NG_W      = 25;
  localparam int GD_W      = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 25;
  localparam int LANE_CNT_W = $clog2(LANES + 1);

  localparam logic [NG_W-1:0] GROUP_COUNT_MAX = NG_W'(16777216);

  localparam logic [MODE_W-1:0] MODE_SUM = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MIN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_ELEMS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_GROUPS  = 2'd2;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd2147483648);

  typedef logic [LANES-1:0][SAMPLE_W-1:0] sample_vec_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  // one item after the lane merge, on its way to the accumulator
  typedef struct packed {
    logic emit;
    logic last;
    logic first;
    logic has;
    acc_t node;
  } item_t;

  function automatic acc_t merge_op(logic [MODE_W-1:0] md, acc_t a, acc_t b);
    acc_t r;
    case (md)
      MODE_MAX: r = (b > a) ? b : a;
      MODE_MIN: r = (b < a) ? b : a;
      default:  r = a + b;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/smm_merge_tree.sv
module smm_merge_tree
  import smm_pkg::*;
(
  input  sample_vec_t             samples,
  input  logic [LANE_CNT_W-1:0]   n_lanes,
  input  logic [MODE_W-1:0]       mode,
  output acc_t                    node_out,
  output logic                    has_out
);

  acc_t node [LANES];
  logic has_v [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      has_v[i] = int'(n_lanes) > i;
      node[i]  = has_v[i] ?
                 {{(ACC_W-SAMPLE_W){samples[i][SAMPLE_W-1]}}, samples[i]} : '0;
    end
    // pairwise levels, lane i absorbs lane i+s
    for (int s = 1; s < LANES; s = s * 2) begin
      for (int i = 0; i + s < LANES; i = i + 2 * s) begin
        if (has_v[i+s]) begin
          node[i]  = has_v[i] ? merge_op(mode, node[i], node[i+s]) : node[i+s];
          has_v[i] = 1'b1;
        end
      end
    end
    node_out = node[0];
    has_out  = has_v[0];
  end

endmodule

>>> rtl/core/smm_accum.sv
module smm_accum
  import smm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_valid,
  input  item_t                      item,
  input  logic [MODE_W-1:0]          mode,
  output logic                       item_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_reduced_value,
  output logic                       out_saturated,
  output logic                       out_last_group
);

  acc_t acc_r, acc_nxt;
  acc_t merged;
  logic out_valid_r;
  logic signed [SAMPLE_W-1:0] value_r;
  logic sat_r, last_r;
  logic take;
  logic hi, lo;

  assign item_ready = !item.emit || !out_valid_r || out_ready;
  assign take       = item_valid && item_ready;

  always_comb begin
    if (!item.has) begin
      merged = acc_r;
    end else if (item.first) begin
      merged = item.node;
    end else begin
      merged = merge_op(mode, acc_r, item.node);
    end
    hi      = merged > SAT_HI;
    lo      = merged < SAT_LO;
    acc_nxt = item.emit ? '0 : merged;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        acc_r <= acc_nxt;
      end
      if (take && item.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word, no reset needed
  always_ff @(posedge clk) begin
    if (take && item.emit) begin
      value_r <= hi ? SAT_HI[SAMPLE_W-1:0] :
                 lo ? SAT_LO[SAMPLE_W-1:0] : merged[SAMPLE_W-1:0];
      sat_r   <= hi || lo;
      last_r  <= item.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_reduced_value = value_r;
  assign out_saturated     = sat_r;
  assign out_last_group    = last_r;

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.emit |=> out_valid_r && (acc_r == '0))
    else $error("accumulator not cleared after group close");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && sat_r |-> (value_r == SAT_HI[SAMPLE_W-1:0]) ||
                             (value_r == SAT_LO[SAMPLE_W-1:0]))
    else $error("saturated word not at a rail");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(take && item.emit))
    else $error("pending result overwritten");

endmodule

>>> rtl/core/segmented_min_max_sum_reduce_unit.sv
// result path: a group's closing input word is registered in the lane stage, then its result
//   word is registered in the accumulator's output register, from where it can be accepted
// throughput: one four-lane word per cycle, set by the accumulator loop (one 53-bit add
//   or compare per cycle); a word that closes a group stalls only while a result is pending
// reset: rst_n synchronous active low; clears config to mode 0, one sample per group and
//   one group per tensor, and clears the sample count, group count and accumulator
module segmented_min_max_sum_reduce_unit
  import smm_pkg::*;
#(
  parameter int MAX_GROUP_ELEMS = 1048576
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample0,
  input  logic signed [SAMPLE_W-1:0] in_sample1,
  input  logic signed [SAMPLE_W-1:0] in_sample2,
  input  logic signed [SAMPLE_W-1:0] in_sample3,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_reduced_value,
  output logic                       out_saturated,
  output logic                       out_last_group
);

  localparam int ES_W = $clog2(MAX_GROUP_ELEMS + 1);
  localparam logic [GE_CFG_W-1:0] GE_MAX = GE_CFG_W'(MAX_GROUP_ELEMS);

  logic [MODE_W-1:0]   mode_r;
  logic [GE_CFG_W-1:0] group_elems_r;
  logic [NG_W-1:0]     num_groups_r;

  logic [ES_W-1:0] elems_seen_r, elems_seen_nxt;
  logic [GD_W-1:0] groups_done_r, groups_done_nxt;

  logic [GE_CFG_W-1:0]   ge_clamp;
  logic [ES_W-1:0]       ge_eff, rem, elems_sum;
  logic [NG_W-1:0]       ng_eff, gd_inc;
  logic [LANE_CNT_W-1:0] n_lanes;
  logic                  emit, last;
  logic                  in_acc;

  sample_vec_t samples;
  acc_t        tree_node;
  logic        tree_has;

  logic  s1_valid_r;
  item_t s1_item_r, s1_item_nxt;
  logic  s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_SUM;
      group_elems_r <= GE_CFG_W'(1);
      num_groups_r  <= NG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:        mode_r        <= cfg_wdata[MODE_W-1:0];
        CFG_GROUP_ELEMS: group_elems_r <= cfg_wdata[GE_CFG_W-1:0];
        CFG_NUM_GROUPS:  num_groups_r  <= cfg_wdata[NG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (group_elems_r == '0) begin
      ge_clamp = GE_CFG_W'(1);
    end else if (group_elems_r > GE_MAX) begin
      ge_clamp = GE_MAX;
    end else begin
      ge_clamp = group_elems_r;
    end
    ge_eff = ge_clamp[ES_W-1:0];

    if (num_groups_r == '0) begin
      ng_eff = NG_W'(1);
    end else if (num_groups_r > GROUP_COUNT_MAX) begin
      ng_eff = GROUP_COUNT_MAX;
    end else begin
      ng_eff = num_groups_r;
    end

    rem     = (ge_eff > elems_seen_r) ? ge_eff - elems_seen_r : '0;
    n_lanes = (32'(rem) < LANES) ? LANE_CNT_W'(rem) : LANE_CNT_W'(LANES);
    // n_lanes never exceeds rem, so the sum stays within the group size
    elems_sum = elems_seen_r + ES_W'(n_lanes);
    emit      = elems_sum >= ge_eff;
    gd_inc    = {1'b0, groups_done_r} + NG_W'(1);
    last      = gd_inc >= ng_eff;

    elems_seen_nxt  = emit ? '0 : elems_sum;
    groups_done_nxt = !emit ? groups_done_r : (last ? '0 : gd_inc[GD_W-1:0]);
  end

  assign samples = {in_sample3, in_sample2, in_sample1, in_sample0};

  smm_merge_tree u_tree (
    .samples  (samples),
    .n_lanes  (n_lanes),
    .mode     (mode_r),
    .node_out (tree_node),
    .has_out  (tree_has)
  );

  assign in_ready = !s1_valid_r || s2_ready;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_item_nxt.emit  = emit;
    s1_item_nxt.last  = emit && last;
    s1_item_nxt.first = elems_seen_r == '0;
    s1_item_nxt.has   = tree_has;
    s1_item_nxt.node  = tree_node;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elems_seen_r  <= '0;
      groups_done_r <= '0;
      s1_valid_r    <= 1'b0;
    end else begin
      if (in_acc) begin
        elems_seen_r  <= elems_seen_nxt;
        groups_done_r <= groups_done_nxt;
        s1_valid_r    <= 1'b1;
      end else if (s2_ready) begin
        s1_valid_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= s1_item_nxt;
    end
  end

  smm_accum u_accum (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (s1_valid_r),
    .item              (s1_item_r),
    .mode              (mode_r),
    .item_ready        (s2_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reduced_value (out_reduced_value),
    .out_saturated     (out_saturated),
    .out_last_group    (out_last_group)
  );

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_ready |=> s1_valid_r && $stable(s1_item_r))
    else $error("lane stage word lost while accumulator stalled");

  a_group_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (elems_seen_r == '0) |=> s1_item_r.has && s1_item_r.first)
    else $error("new group opened without lanes");

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && emit && last |=> groups_done_r == '0)
    else $error("group count did not wrap on last group");

endmodule
